>>> sv/vector2_refract_assert.svh
`ifndef VECTOR2_REFRACT_ASSERT_SVH
`define VECTOR2_REFRACT_ASSERT_SVH

// same-cycle implication check
`define V2R_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// next-cycle implication check
`define V2R_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

>>> sv/v2r_pkg.sv
`default_nettype none

package v2r_pkg;

   localparam int WORD_BITS = 16;
   localparam int REG_BITS = 16;
   localparam int IW = 41;
   localparam int PW = 84;
   localparam int SPLIT = 20;
   localparam int CSR_IDX_BITS = 1;

   localparam logic [CSR_IDX_BITS-1:0] REG_INCIDENT = 1'b0;
   localparam logic [CSR_IDX_BITS-1:0] REG_TRANSMITTED = 1'b1;
   localparam logic [REG_BITS-1:0] INDEX_RESET = 16'd4096;

   typedef logic signed [WORD_BITS-1:0] word_type;
   typedef logic signed [IW-1:0] ival_type;
   typedef logic signed [PW-1:0] prod_type;

   localparam ival_type LIM = 41'sd1099511627775;
   localparam prod_type P_LIM = 84'sd1099511627775;
   localparam prod_type P_SAT = 84'sd4611686018427387904;

   typedef struct packed {
      word_type dir_x;
      word_type dir_y;
      word_type normal_x;
      word_type normal_y;
   } req_type;

   typedef struct packed {
      word_type out_x;
      word_type out_y;
      logic total_reflection;
      logic clipped;
   } rsp_type;

   typedef struct packed {
      ival_type n;
      ival_type nn;
      logic busy;
   } cfg_type;

   typedef struct packed {
      logic tir;
      ival_type nd;
      ival_type ndx;
      ival_type ndy;
      ival_type rx;
      ival_type ry;
      word_type dir_x;
      word_type dir_y;
      word_type normal_x;
      word_type normal_y;
   } side_type;

   function automatic ival_type clamp(input prod_type v);
      if (v > P_LIM) return LIM;
      if (v < -P_LIM) return -LIM;
      return v[IW-1:0];
   endfunction

   // scale a full product by 2^-frac, optional round half up, with saturation
   function automatic ival_type fx_scale(input prod_type p, input int frac, input logic rnd);
      prod_type q;
      if (p > P_SAT || p < -P_SAT) return (p < 0) ? -LIM : LIM;
      q = p;
      if (rnd) q = q + (prod_type'(1) <<< (frac - 1));
      return clamp(q >>> frac);
   endfunction

endpackage

`default_nettype wire

>>> sv/v2r_cfg.sv
`default_nettype none

`include "vector2_refract_assert.svh"

module v2r_cfg #(
   parameter int FRAC_BITS = 12
) (
   input  logic clock,
   input  logic reset,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [v2r_pkg::CSR_IDX_BITS-1:0] csr_index,
   input  logic [v2r_pkg::REG_BITS-1:0] csr_data,
   output v2r_pkg::cfg_type cfg_out
);

   localparam int RB = v2r_pkg::REG_BITS;
   localparam int DVW = RB + FRAC_BITS;
   localparam int CW = $clog2(DVW);
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV = 2'd1;
   localparam logic [1:0] ST_SQR = 2'd2;
   localparam v2r_pkg::ival_type ONE_FX = v2r_pkg::ival_type'(1) <<< FRAC_BITS;

   logic [1:0] state_ff, state_in;
   logic [RB-1:0] inc_ff, inc_in, tra_ff, tra_in;
   logic [DVW-1:0] qr_ff, qr_in;
   logic [RB-1:0] rem_ff, rem_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   v2r_pkg::ival_type n_ff, n_in, nn_ff, nn_in;
   logic [RB:0] trial;
   logic [RB:0] diff;
   logic ge;
   logic [2*DVW-1:0] nsq;
   logic wr;

   assign csr_ready = (state_ff == ST_IDLE);
   assign wr = csr_valid && csr_ready;
   assign trial = {rem_ff, qr_ff[DVW-1]};
   assign ge = trial >= {1'b0, tra_ff};
   assign diff = trial - {1'b0, tra_ff};
   assign nsq = qr_ff * qr_ff;

   always_comb begin
      state_in = state_ff;
      inc_in = inc_ff;
      tra_in = tra_ff;
      qr_in = qr_ff;
      rem_in = rem_ff;
      cnt_in = cnt_ff;
      n_in = n_ff;
      nn_in = nn_ff;
      if (wr && csr_index == v2r_pkg::REG_INCIDENT) inc_in = csr_data;
      if (wr && csr_index == v2r_pkg::REG_TRANSMITTED) tra_in = csr_data;
      case (state_ff)
         ST_IDLE: begin
            if (wr) begin
               state_in = ST_DIV;
               qr_in = {inc_in, {FRAC_BITS{1'b0}}};
               rem_in = '0;
               cnt_in = '0;
            end
         end
         ST_DIV: begin
            rem_in = ge ? diff[RB-1:0] : trial[RB-1:0];
            qr_in = {qr_ff[DVW-2:0], ge};
            cnt_in = cnt_ff + CW'(1);
            if (cnt_ff == CW'(DVW - 1)) state_in = ST_SQR;
         end
         ST_SQR: begin
            if (tra_ff == '0) begin
               n_in = v2r_pkg::LIM;
               nn_in = v2r_pkg::LIM;
            end else begin
               n_in = v2r_pkg::ival_type'(qr_ff);
               nn_in = v2r_pkg::fx_scale(v2r_pkg::prod_type'(nsq), FRAC_BITS, 1'b0);
            end
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         inc_ff <= v2r_pkg::INDEX_RESET;
         tra_ff <= v2r_pkg::INDEX_RESET;
         n_ff <= ONE_FX;
         nn_ff <= ONE_FX;
         cnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         inc_ff <= inc_in;
         tra_ff <= tra_in;
         n_ff <= n_in;
         nn_ff <= nn_in;
         cnt_ff <= cnt_in;
      end
      qr_ff <= qr_in;
      rem_ff <= rem_in;
   end

   assign cfg_out.n = n_ff;
   assign cfg_out.nn = nn_ff;
   assign cfg_out.busy = (state_ff != ST_IDLE);

   `V2R_ASSERT_NXT(a_write_starts_update, clock, reset, wr, state_ff == ST_DIV)

endmodule

`default_nettype wire

>>> sv/v2r_cell.sv
`default_nettype none

module v2r_cell #(
   parameter int XW = 52,
   parameter int SHIFT = 50
) (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   input  logic [XW-1:0] in_x,
   input  logic [XW-1:0] in_res,
   input  v2r_pkg::side_type in_side,
   output logic out_valid,
   output logic [XW-1:0] out_x,
   output logic [XW-1:0] out_res,
   output v2r_pkg::side_type out_side
);

   localparam logic [XW-1:0] BIT_VAL = {{(XW-1){1'b0}}, 1'b1} << SHIFT;

   logic valid_ff;
   logic [XW-1:0] x_ff, x_in, res_ff, res_in, trial;
   v2r_pkg::side_type side_ff;
   logic take;

   assign trial = in_res + BIT_VAL;
   assign take = in_x >= trial;
   assign x_in = take ? in_x - trial : in_x;
   assign res_in = take ? (in_res >> 1) + BIT_VAL : in_res >> 1;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      x_ff <= x_in;
      res_ff <= res_in;
      side_ff <= in_side;
   end

   assign out_valid = valid_ff;
   assign out_x = x_ff;
   assign out_res = res_ff;
   assign out_side = side_ff;

endmodule

`default_nettype wire

>>> sv/vector2_refract.sv
// 2D Snell refraction of a direction against a surface normal, signed fixed point.
// One word is taken per clock whenever busy is low, and its result appears on rsp_word
// with rsp_valid high for one cycle once it has passed the pipeline, whose depth grows
// with the square-root cell row, one result bit per cell. The receiver cannot
// stall, so results must be taken when strobed. A register write makes busy go high
// while the index ratio is recomputed by a bit-serial divider and then squared; writes
// are only meant while no word is in flight.
`default_nettype none

`include "vector2_refract_assert.svh"

module vector2_refract #(
   parameter int FRAC_BITS = 12
) (
   input  logic clock,
   input  logic reset,
   input  logic start,
   output logic busy,
   input  v2r_pkg::req_type req_word,
   output logic rsp_valid,
   output v2r_pkg::rsp_type rsp_word,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [v2r_pkg::CSR_IDX_BITS-1:0] csr_index,
   input  logic [v2r_pkg::REG_BITS-1:0] csr_data
);

   localparam int W = v2r_pkg::WORD_BITS;
   localparam int IW = v2r_pkg::IW;
   localparam int S = v2r_pkg::SPLIT;
   localparam int DW = 2 * W + 1 - FRAC_BITS;
   localparam int EW_RAW = (4 * W - 3 * FRAC_BITS > FRAC_BITS + 2) ?
                           4 * W - 3 * FRAC_BITS : FRAC_BITS + 2;
   localparam int EW = (EW_RAW + 1 > IW) ? IW : EW_RAW + 1;
   localparam int XW = IW - 1 + FRAC_BITS;
   localparam int STEPS = (XW + 1) / 2;
   localparam int LAT = 12 + STEPS;
   localparam v2r_pkg::prod_type ONE_P = v2r_pkg::prod_type'(1) <<< FRAC_BITS;
   localparam logic signed [IW:0] W_MAX = (IW + 1)'((2 ** (W - 1)) - 1);
   localparam logic signed [IW:0] W_MIN = -W_MAX - 1;

   v2r_pkg::cfg_type cfg;
   logic accept;

   logic [7:0] valid_ff, valid_in;
   v2r_pkg::req_type req_ff [4];

   logic signed [2*W-1:0] p1_ff, p1_in, p2_ff, p2_in;
   logic signed [2*W:0] dot_sum, dot_shift;
   logic signed [DW-1:0] d_ff, d_in, d4_ff;
   logic signed [2*DW-1:0] dsq_prod;
   v2r_pkg::ival_type dsq_ff, dsq_in;
   logic signed [S+DW:0] ndl_ff, ndl_in, ndh_ff, ndh_in;
   logic signed [S+W:0] ndxl_ff, ndxl_in, ndxh_ff, ndxh_in;
   logic signed [S+W:0] ndyl_ff, ndyl_in, ndyh_ff, ndyh_in;

   v2r_pkg::ival_type e_full;
   logic signed [EW-1:0] e_ff, e_in;
   logic signed [DW:0] dd_ff, dd_in;
   v2r_pkg::side_type side5_ff, side5_in;

   logic signed [S+EW:0] ml_ff, ml_in, mh_ff, mh_in;
   logic signed [DW+W:0] rxp_ff, rxp_in, ryp_ff, ryp_in;
   v2r_pkg::side_type side6_ff;

   v2r_pkg::ival_type m_ff, m_in;
   v2r_pkg::side_type side7_ff, side7_in;

   v2r_pkg::ival_type k_ff, k_in;
   v2r_pkg::side_type side8_ff, side8_in;

   logic cval [STEPS+1];
   logic [XW-1:0] cx [STEPS+1];
   logic [XW-1:0] cres [STEPS+1];
   v2r_pkg::side_type cside [STEPS+1];

   logic valid9_ff, valid10_ff, valid11_ff, rsp_valid_ff;
   v2r_pkg::ival_type s_ff, s_in;
   v2r_pkg::side_type side9_ff, side10_ff, side11_ff;
   logic signed [S+W:0] sxl_ff, sxl_in, sxh_ff, sxh_in, syl_ff, syl_in, syh_ff, syh_in;
   v2r_pkg::ival_type sx_ff, sx_in, sy_ff, sy_in;
   logic signed [IW:0] diff_x, diff_y;
   logic [W:0] sat_x, sat_y;
   v2r_pkg::rsp_type rsp_ff, rsp_in;

   function automatic logic [W:0] sat_word(input logic signed [IW:0] v);
      if (v > W_MAX) return {1'b1, 1'b0, {(W-1){1'b1}}};
      if (v < W_MIN) return {1'b1, 1'b1, {(W-1){1'b0}}};
      return {1'b0, v[W-1:0]};
   endfunction

   v2r_cfg #(.FRAC_BITS(FRAC_BITS)) u_cfg (
      .clock(clock),
      .reset(reset),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data),
      .cfg_out(cfg)
   );

   assign busy = cfg.busy;
   assign accept = start && !busy;
   assign valid_in = {valid_ff[6:0], accept};

   // dot product, squares and index products
   assign p1_in = req_ff[0].dir_x * req_ff[0].normal_x;
   assign p2_in = req_ff[0].dir_y * req_ff[0].normal_y;
   assign dot_sum = (2 * W + 1)'(p1_ff) + (2 * W + 1)'(p2_ff);
   assign dot_shift = dot_sum >>> FRAC_BITS;
   assign d_in = dot_shift[DW-1:0];

   assign dsq_prod = d_ff * d_ff;
   assign dsq_in = v2r_pkg::fx_scale(v2r_pkg::prod_type'(dsq_prod), FRAC_BITS, 1'b0);
   assign ndl_in = $signed({1'b0, cfg.n[S-1:0]}) * d_ff;
   assign ndh_in = $signed({1'b0, cfg.n[IW-2:S]}) * d_ff;
   assign ndxl_in = $signed({1'b0, cfg.n[S-1:0]}) * req_ff[2].dir_x;
   assign ndxh_in = $signed({1'b0, cfg.n[IW-2:S]}) * req_ff[2].dir_x;
   assign ndyl_in = $signed({1'b0, cfg.n[S-1:0]}) * req_ff[2].dir_y;
   assign ndyh_in = $signed({1'b0, cfg.n[IW-2:S]}) * req_ff[2].dir_y;

   assign e_full = v2r_pkg::clamp(ONE_P - v2r_pkg::prod_type'(dsq_ff));
   assign e_in = e_full[EW-1:0];
   assign dd_in = {d4_ff, 1'b0};

   always_comb begin
      side5_in = '0;
      side5_in.nd = v2r_pkg::fx_scale((v2r_pkg::prod_type'(ndh_ff) <<< S)
                                      + v2r_pkg::prod_type'(ndl_ff), FRAC_BITS, 1'b0);
      side5_in.ndx = v2r_pkg::fx_scale((v2r_pkg::prod_type'(ndxh_ff) <<< S)
                                       + v2r_pkg::prod_type'(ndxl_ff), FRAC_BITS, 1'b1);
      side5_in.ndy = v2r_pkg::fx_scale((v2r_pkg::prod_type'(ndyh_ff) <<< S)
                                       + v2r_pkg::prod_type'(ndyl_ff), FRAC_BITS, 1'b1);
      side5_in.dir_x = req_ff[3].dir_x;
      side5_in.dir_y = req_ff[3].dir_y;
      side5_in.normal_x = req_ff[3].normal_x;
      side5_in.normal_y = req_ff[3].normal_y;
   end

   // discriminant and reflection terms
   assign ml_in = $signed({1'b0, cfg.nn[S-1:0]}) * e_ff;
   assign mh_in = $signed({1'b0, cfg.nn[IW-2:S]}) * e_ff;
   assign rxp_in = dd_ff * side5_ff.normal_x;
   assign ryp_in = dd_ff * side5_ff.normal_y;

   assign m_in = v2r_pkg::fx_scale((v2r_pkg::prod_type'(mh_ff) <<< S)
                                   + v2r_pkg::prod_type'(ml_ff), FRAC_BITS, 1'b0);
   always_comb begin
      side7_in = side6_ff;
      side7_in.rx = v2r_pkg::fx_scale(v2r_pkg::prod_type'(rxp_ff), FRAC_BITS, 1'b1);
      side7_in.ry = v2r_pkg::fx_scale(v2r_pkg::prod_type'(ryp_ff), FRAC_BITS, 1'b1);
   end

   assign k_in = v2r_pkg::clamp(ONE_P - v2r_pkg::prod_type'(m_ff));
   always_comb begin
      side8_in = side7_ff;
      side8_in.tir = k_in[IW-1];
   end

   // square-root cell row
   assign cval[0] = valid_ff[7];
   assign cx[0] = side8_ff.tir ? '0 : {k_ff[IW-2:0], {FRAC_BITS{1'b0}}};
   assign cres[0] = '0;
   assign cside[0] = side8_ff;

   for (genvar i = 0; i < STEPS; i++) begin : g_root
      v2r_cell #(.XW(XW), .SHIFT(2 * (STEPS - 1 - i))) u_cell (
         .clock(clock),
         .reset(reset),
         .in_valid(cval[i]),
         .in_x(cx[i]),
         .in_res(cres[i]),
         .in_side(cside[i]),
         .out_valid(cval[i+1]),
         .out_x(cx[i+1]),
         .out_res(cres[i+1]),
         .out_side(cside[i+1])
      );
   end

   // refraction terms and output
   assign s_in = v2r_pkg::clamp(v2r_pkg::prod_type'(cres[STEPS])
                                - v2r_pkg::prod_type'(cside[STEPS].nd));
   assign sxl_in = $signed({1'b0, s_ff[S-1:0]}) * side9_ff.normal_x;
   assign sxh_in = $signed(s_ff[IW-1:S]) * side9_ff.normal_x;
   assign syl_in = $signed({1'b0, s_ff[S-1:0]}) * side9_ff.normal_y;
   assign syh_in = $signed(s_ff[IW-1:S]) * side9_ff.normal_y;
   assign sx_in = v2r_pkg::fx_scale((v2r_pkg::prod_type'(sxh_ff) <<< S)
                                    + v2r_pkg::prod_type'(sxl_ff), FRAC_BITS, 1'b1);
   assign sy_in = v2r_pkg::fx_scale((v2r_pkg::prod_type'(syh_ff) <<< S)
                                    + v2r_pkg::prod_type'(syl_ff), FRAC_BITS, 1'b1);

   assign diff_x = side11_ff.tir ?
                   (IW + 1)'(side11_ff.rx) - (IW + 1)'(side11_ff.dir_x) :
                   (IW + 1)'(side11_ff.ndx) - (IW + 1)'(sx_ff);
   assign diff_y = side11_ff.tir ?
                   (IW + 1)'(side11_ff.ry) - (IW + 1)'(side11_ff.dir_y) :
                   (IW + 1)'(side11_ff.ndy) - (IW + 1)'(sy_ff);
   assign sat_x = sat_word(diff_x);
   assign sat_y = sat_word(diff_y);

   always_comb begin
      rsp_in.out_x = sat_x[W-1:0];
      rsp_in.out_y = sat_y[W-1:0];
      rsp_in.total_reflection = side11_ff.tir;
      rsp_in.clipped = sat_x[W] | sat_y[W];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         valid9_ff <= 1'b0;
         valid10_ff <= 1'b0;
         valid11_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         valid9_ff <= cval[STEPS];
         valid10_ff <= valid9_ff;
         valid11_ff <= valid10_ff;
         rsp_valid_ff <= valid11_ff;
      end
      req_ff[0] <= req_word;
      req_ff[1] <= req_ff[0];
      req_ff[2] <= req_ff[1];
      req_ff[3] <= req_ff[2];
      p1_ff <= p1_in;
      p2_ff <= p2_in;
      d_ff <= d_in;
      d4_ff <= d_ff;
      dsq_ff <= dsq_in;
      ndl_ff <= ndl_in;
      ndh_ff <= ndh_in;
      ndxl_ff <= ndxl_in;
      ndxh_ff <= ndxh_in;
      ndyl_ff <= ndyl_in;
      ndyh_ff <= ndyh_in;
      e_ff <= e_in;
      dd_ff <= dd_in;
      side5_ff <= side5_in;
      ml_ff <= ml_in;
      mh_ff <= mh_in;
      rxp_ff <= rxp_in;
      ryp_ff <= ryp_in;
      side6_ff <= side5_ff;
      m_ff <= m_in;
      side7_ff <= side7_in;
      k_ff <= k_in;
      side8_ff <= side8_in;
      s_ff <= s_in;
      side9_ff <= cside[STEPS];
      sxl_ff <= sxl_in;
      sxh_ff <= sxh_in;
      syl_ff <= syl_in;
      syh_ff <= syh_in;
      side10_ff <= side9_ff;
      sx_ff <= sx_in;
      sy_ff <= sy_in;
      side11_ff <= side10_ff;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word = rsp_ff;

   `V2R_ASSERT_IMP(a_word_latency, clock, reset, accept, ##LAT rsp_valid)
   `V2R_ASSERT_IMP(a_no_stray_word, clock, reset, rsp_valid, $past(accept, LAT))
   `V2R_ASSERT_IMP(a_root_remainder, clock, reset, cval[STEPS], cx[STEPS] <= {cres[STEPS], 1'b0})

endmodule

`default_nettype wire

>>> dv/tb_vector2_refract.sv
`timescale 1ns / 100ps

module tb_vector2_refract;

   localparam int FRAC = 12;
   localparam longint SAT_BOUND = (64'sd1 <<< 40) - 1;
   localparam int DRAIN_CYCLES = 60;
   localparam int STALL_LIMIT = 5000;

   class refract_scoreboard;
      longint unsigned incident;
      longint unsigned transmitted;
      v2r_pkg::rsp_type pending_q[$];
      int errors;

      function new();
         incident = v2r_pkg::INDEX_RESET;
         transmitted = v2r_pkg::INDEX_RESET;
         errors = 0;
      endfunction

      function longint flr(longint v, int s);
         if (v >= 0) return v >>> s;
         return -((-(v + 1)) >>> s) - 1;
      endfunction

      function longint sat(longint v);
         if (v > SAT_BOUND) return SAT_BOUND;
         if (v < -SAT_BOUND) return -SAT_BOUND;
         return v;
      endfunction

      function longint fxmul(longint a, longint b, bit rnd);
         longint ua, ub, p;
         bit neg;
         ua = (a < 0) ? -a : a;
         ub = (b < 0) ? -b : b;
         neg = (a < 0) != (b < 0);
         if (ua != 0 && ub > (64'sd1 <<< 62) / ua) return neg ? -SAT_BOUND : SAT_BOUND;
         p = ua * ub;
         if (neg) p = -p;
         if (rnd) p = p + (64'sd1 <<< (FRAC - 1));
         return sat(flr(p, FRAC));
      endfunction

      function longint root_floor(longint unsigned x);
         longint unsigned res, b;
         res = 0;
         b = 64'd1 << 62;
         while (b > x) b = b >> 2;
         while (b != 0) begin
            if (x >= res + b) begin
               x = x - (res + b);
               res = (res >> 1) + b;
            end else begin
               res = res >> 1;
            end
            b = b >> 2;
         end
         return longint'(res);
      endfunction

      function longint to_word(longint v, ref bit clip);
         if (v > 32767) begin
            clip = 1;
            return 32767;
         end
         if (v < -32768) begin
            clip = 1;
            return -32768;
         end
         return v;
      endfunction

      function void note(v2r_pkg::req_type r);
         longint dx, dy, nx, ny, one, p1, p2, half, d, n, k, ox, oy, dd, rt, s;
         bit tir, clip;
         v2r_pkg::rsp_type e;
         dx = longint'(r.dir_x);
         dy = longint'(r.dir_y);
         nx = longint'(r.normal_x);
         ny = longint'(r.normal_y);
         one = 64'sd1 <<< FRAC;
         clip = 0;
         p1 = dx * nx;
         p2 = dy * ny;
         half = flr(p1, 1) + flr(p2, 1) + (p1 & p2 & 1);
         d = sat(flr(half, FRAC - 1));
         if (transmitted == 0) n = SAT_BOUND;
         else n = sat(longint'((incident << FRAC) / transmitted));
         k = sat(one - fxmul(fxmul(n, n, 0), sat(one - fxmul(d, d, 0)), 0));
         tir = k < 0;
         if (tir) begin
            dd = sat(d + d);
            ox = fxmul(dd, nx, 1) - dx;
            oy = fxmul(dd, ny, 1) - dy;
         end else begin
            rt = root_floor(longint'(k) << FRAC);
            s = sat(rt - fxmul(n, d, 0));
            ox = fxmul(n, dx, 1) - fxmul(s, nx, 1);
            oy = fxmul(n, dy, 1) - fxmul(s, ny, 1);
         end
         e.out_x = v2r_pkg::word_type'(to_word(ox, clip));
         e.out_y = v2r_pkg::word_type'(to_word(oy, clip));
         e.total_reflection = tir;
         e.clipped = clip;
         pending_q.push_back(e);
      endfunction

      task report(string what, longint got, longint want);
         $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
         errors++;
      endtask

      task check(v2r_pkg::rsp_type r);
         v2r_pkg::rsp_type e;
         if (pending_q.size() == 0) begin
            report("unexpected word", 0, 1);
            return;
         end
         e = pending_q.pop_front();
         if (r.out_x !== e.out_x) report("out_x", r.out_x, e.out_x);
         if (r.out_y !== e.out_y) report("out_y", r.out_y, e.out_y);
         if (r.total_reflection !== e.total_reflection)
            report("total_reflection", r.total_reflection, e.total_reflection);
         if (r.clipped !== e.clipped) report("clipped", r.clipped, e.clipped);
      endtask
   endclass

   logic clock = 0;
   logic reset = 1;
   logic start = 0;
   logic busy;
   v2r_pkg::req_type req_word = '0;
   logic rsp_valid;
   v2r_pkg::rsp_type rsp_word;
   logic csr_valid = 0;
   logic csr_ready;
   logic [v2r_pkg::CSR_IDX_BITS-1:0] csr_index = v2r_pkg::REG_INCIDENT;
   logic [v2r_pkg::REG_BITS-1:0] csr_data = '0;

   refract_scoreboard sb = new();
   int stall_count = 0;
   bit no_idle;

   vector2_refract i_dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_word(req_word),
      .rsp_valid(rsp_valid),
      .rsp_word(rsp_word),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_valid) sb.check(rsp_word);
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
         stall_count <= 0;
      end else begin
         stall_count <= stall_count + 1;
         if (stall_count >= STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   task send_word(v2r_pkg::req_type w);
      while (!no_idle && $urandom_range(99) < 22) begin
         start = 0;
         @(negedge clock);
      end
      start = 1;
      req_word = w;
      forever begin
         @(posedge clock);
         if (!busy) break;
      end
      sb.note(w);
      @(negedge clock);
   endtask

   task write_index(logic [v2r_pkg::CSR_IDX_BITS-1:0] idx,
                    logic [v2r_pkg::REG_BITS-1:0] value);
      start = 0;
      while (sb.pending_q.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      csr_valid = 1;
      csr_index = idx;
      csr_data = value;
      forever begin
         @(posedge clock);
         if (csr_ready) break;
      end
      if (idx == v2r_pkg::REG_INCIDENT) sb.incident = value;
      else sb.transmitted = value;
      @(negedge clock);
      csr_valid = 0;
   endtask

   function v2r_pkg::word_type rand_comp();
      if ($urandom_range(99) < 70) return v2r_pkg::word_type'($urandom_range(8192) - 4096);
      return v2r_pkg::word_type'($urandom);
   endfunction

   function v2r_pkg::req_type mk(int dx, int dy, int nx, int ny);
      v2r_pkg::req_type w;
      w.dir_x = v2r_pkg::word_type'(dx);
      w.dir_y = v2r_pkg::word_type'(dy);
      w.normal_x = v2r_pkg::word_type'(nx);
      w.normal_y = v2r_pkg::word_type'(ny);
      return w;
   endfunction

   task directed_words();
      send_word(mk(0, 0, 0, 0));
      send_word(mk(32767, 32767, 32767, 32767));
      send_word(mk(-32768, -32768, -32768, -32768));
      send_word(mk(-32768, 32767, 32767, -32768));
      send_word(mk(0, -4096, 0, 4096));
      send_word(mk(4096, 0, 0, 4096));
      send_word(mk(2896, -2896, 0, 4096));
      send_word(mk(4000, -900, 0, 4096));
      send_word(mk(-4096, 0, 4096, 0));
      send_word(mk(1, -1, -1, 1));
      send_word(mk(16'hAAAA, 16'h5555, 16'h5555, 16'hAAAA));
   endtask

   logic [v2r_pkg::REG_BITS-1:0] inc_set [6] =
      '{16'd4096, 16'd6144, 16'd4096, 16'd65535, 16'd1, 16'd5461};
   logic [v2r_pkg::REG_BITS-1:0] trn_set [6] =
      '{16'd4096, 16'd4096, 16'd6144, 16'd1, 16'd65535, 16'd4096};
   v2r_pkg::req_type w;

   initial begin
      no_idle = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 0;
      for (int ph = 0; ph < 6; ph++) begin
         if (ph != 0) begin
            write_index(v2r_pkg::REG_INCIDENT, inc_set[ph]);
            write_index(v2r_pkg::REG_TRANSMITTED, trn_set[ph]);
         end
         no_idle = (ph == 2);
         directed_words();
         for (int i = 0; i < 98; i++) begin
            w.dir_x = rand_comp();
            w.dir_y = rand_comp();
            w.normal_x = rand_comp();
            w.normal_y = rand_comp();
            send_word(w);
         end
      end
      start = 0;
      while (sb.pending_q.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (sb.errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
